FILE: rtl/dtq_pkg.sv
// Shared types and constants for the deadline timer queue.
// Used by dtq_cell, dtq_ctrl and deadline_timer_queue; depends on nothing.
`default_nettype none

package dtq_pkg;

    localparam int TIME_BITS     = 48;
    localparam int ID_BITS       = 16;
    localparam int REQ_BITS      = 2;
    localparam int STATUS_BITS   = 3;
    localparam int S_TDATA_W     = 112;
    localparam int M_TDATA_W     = 16;
    localparam int DEF_MAX_TASKS = 16;

    localparam logic [REQ_BITS-1:0] REQ_REGISTER   = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_UNREGISTER = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_TICK       = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_REGISTERED = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNREG      = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FIRED      = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NONE       = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REG,
        S_UNREG,
        S_TICK
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic [TIME_BITS-1:0] deadline;
        logic [ID_BITS-1:0]   id;
    } entry_t;

    // Wave state handed from one cell to the next during a sweep.
    typedef struct packed {
        logic                 rm;     // removal point already passed
        logic                 bf;     // a due entry has been found
        logic [TIME_BITS-1:0] bd;     // earliest due deadline so far
        logic [ID_BITS-1:0]   bid;    // its id
    } carry_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                 step;
        logic                 tick;
        logic                 tgt_v;
        logic [ID_BITS-1:0]   key;
        logic [TIME_BITS-1:0] now;
        logic                 wr_en;
        logic [TIME_BITS-1:0] wr_deadline;
        logic [ID_BITS-1:0]   wr_id;
    } ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/dtq_cell.sv
// One slot of the timer row: holds an entry and takes part in the sweep wave.
// Depends on dtq_pkg.
`default_nettype none

module dtq_cell #(
    parameter int MAX_TASKS = dtq_pkg::DEF_MAX_TASKS,
    parameter int INDEX     = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dtq_pkg::ctrl_t                ctrl,
    input  wire logic [$clog2(MAX_TASKS)-1:0]  pos,
    input  wire logic [$clog2(MAX_TASKS)-1:0]  tgt,
    input  wire logic                          prev_valid,
    input  wire dtq_pkg::carry_t               carry_in,
    input  wire logic [$clog2(MAX_TASKS)-1:0]  bidx_in,
    input  wire dtq_pkg::entry_t               next_entry,
    output dtq_pkg::entry_t                    entry,
    output dtq_pkg::carry_t                    carry_q,
    output logic [$clog2(MAX_TASKS)-1:0]       bidx_q,
    output dtq_pkg::carry_t                    carry_out,
    output logic [$clog2(MAX_TASKS)-1:0]       bidx_out
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam logic [IW-1:0] OWN = IW'(INDEX);

    logic                        valid_reg, valid_next;
    logic [dtq_pkg::TIME_BITS-1:0] dl_reg, dl_next;
    logic [dtq_pkg::ID_BITS-1:0]   id_reg, id_next;
    dtq_pkg::carry_t             carry_reg, carry_next;
    logic [IW-1:0]               bidx_reg, bidx_next;

    logic            active;
    logic            hit;
    logic            rm_out;
    logic            take;
    dtq_pkg::entry_t mine;
    dtq_pkg::entry_t r;

    assign mine    = '{valid: valid_reg, deadline: dl_reg, id: id_reg};
    assign entry   = mine;
    assign carry_q = carry_reg;
    assign bidx_q  = bidx_reg;

    always_comb begin
        active = ctrl.step && (pos == OWN);
        if (ctrl.tick) begin
            hit = ctrl.tgt_v && (tgt == OWN);
        end else begin
            hit = !carry_in.rm && valid_reg && (id_reg == ctrl.key);
        end
        rm_out = carry_in.rm || hit;
        r      = rm_out ? next_entry : mine;
        take   = ctrl.tick && r.valid && (r.deadline <= ctrl.now)
                 && (!carry_in.bf || (r.deadline < carry_in.bd));

        carry_out    = carry_in;
        carry_out.rm = rm_out;
        bidx_out     = bidx_in;
        if (take) begin
            carry_out.bf  = 1'b1;
            carry_out.bd  = r.deadline;
            carry_out.bid = r.id;
            bidx_out      = OWN;
        end

        valid_next = valid_reg;
        dl_next    = dl_reg;
        id_next    = id_reg;
        carry_next = carry_reg;
        bidx_next  = bidx_reg;
        if (active) begin
            carry_next = carry_out;
            bidx_next  = bidx_out;
            if (rm_out) begin
                valid_next = next_entry.valid;
                dl_next    = next_entry.deadline;
                id_next    = next_entry.id;
            end
        end
        // append at the first free slot
        if (ctrl.wr_en && !valid_reg && prev_valid) begin
            valid_next = 1'b1;
            dl_next    = ctrl.wr_deadline;
            id_next    = ctrl.wr_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge aclk) begin
        dl_reg   <= dl_next;
        id_reg   <= id_next;
        bidx_reg <= bidx_next;
    end

endmodule

`default_nettype wire

FILE: rtl/dtq_ctrl.sv
// Request sequencer and output register for the timer row.
// Drives the sweep position and broadcast controls; depends on dtq_pkg.
`default_nettype none

module dtq_ctrl #(
    parameter int MAX_TASKS = dtq_pkg::DEF_MAX_TASKS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [dtq_pkg::S_TDATA_W-1:0]         s_tdata,
    input  wire logic [dtq_pkg::REQ_BITS-1:0]          s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [dtq_pkg::M_TDATA_W-1:0]              m_tdata,
    output logic                                       m_tlast,
    output logic [dtq_pkg::STATUS_BITS-1:0]            m_tuser,
    output dtq_pkg::ctrl_t                             cell_ctrl,
    output logic [$clog2(MAX_TASKS)-1:0]               pos,
    output logic [$clog2(MAX_TASKS)-1:0]               tgt,
    input  wire dtq_pkg::carry_t                       tail_carry,
    input  wire logic [$clog2(MAX_TASKS)-1:0]          tail_bidx,
    input  wire logic                                  table_full
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam logic [IW-1:0] LAST_POS = IW'(MAX_TASKS - 1);
    localparam int TB = dtq_pkg::TIME_BITS;
    localparam int IB = dtq_pkg::ID_BITS;

    dtq_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   pos_reg, pos_next;
    logic [IW-1:0]   tgt_reg, tgt_next;
    logic            tgt_v_reg, tgt_v_next;
    logic            pend_reg, pend_next;
    logic [IB-1:0]   pend_id_reg, pend_id_next;
    logic [IB-1:0]   next_id_reg, next_id_next;
    logic [TB-1:0]   dl_reg, dl_next;
    logic [IB-1:0]   key_reg, key_next;
    logic [TB-1:0]   now_reg, now_next;
    logic                           m_valid_reg, m_valid_next;
    logic [dtq_pkg::STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic [IB-1:0]                  m_id_reg, m_id_next;
    logic                           m_last_reg, m_last_next;

    logic out_free;
    logic at_end;
    logic step;
    logic wr_en;
    logic emit;
    logic [dtq_pkg::STATUS_BITS-1:0] e_status;
    logic [IB-1:0]                   e_id;
    logic                            e_last;

    assign out_free = !m_valid_reg || m_tready;
    assign at_end   = (pos_reg == LAST_POS);
    assign s_tready = (state_reg == dtq_pkg::S_IDLE);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_id_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;
    assign pos      = pos_reg;
    assign tgt      = tgt_reg;

    always_comb begin
        cell_ctrl.step        = step;
        cell_ctrl.tick        = (state_reg == dtq_pkg::S_TICK);
        cell_ctrl.tgt_v       = tgt_v_reg;
        cell_ctrl.key         = key_reg;
        cell_ctrl.now         = now_reg;
        cell_ctrl.wr_en       = wr_en;
        cell_ctrl.wr_deadline = dl_reg;
        cell_ctrl.wr_id       = next_id_reg;
    end

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        tgt_next     = tgt_reg;
        tgt_v_next   = tgt_v_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        next_id_next = next_id_reg;
        dl_next      = dl_reg;
        key_next     = key_reg;
        now_next     = now_reg;
        step         = 1'b0;
        wr_en        = 1'b0;
        emit         = 1'b0;
        e_status     = dtq_pkg::ST_NONE;
        e_id         = '0;
        e_last       = 1'b1;

        unique case (state_reg)
            dtq_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    dl_next  = s_tdata[TB-1:0];
                    key_next = s_tdata[TB+IB-1:TB];
                    now_next = s_tdata[2*TB+IB-1:TB+IB];
                    pos_next = '0;
                    unique case (s_tuser)
                        dtq_pkg::REQ_REGISTER:   state_next = dtq_pkg::S_REG;
                        dtq_pkg::REQ_UNREGISTER: state_next = dtq_pkg::S_UNREG;
                        dtq_pkg::REQ_TICK: begin
                            state_next = dtq_pkg::S_TICK;
                            pend_next  = 1'b0;
                            tgt_v_next = 1'b0;
                        end
                        default: state_next = dtq_pkg::S_IDLE;
                    endcase
                end
            end
            dtq_pkg::S_REG: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = dtq_pkg::S_IDLE;
                    if (table_full) begin
                        e_status = dtq_pkg::ST_FULL;
                    end else begin
                        e_status     = dtq_pkg::ST_REGISTERED;
                        e_id         = next_id_reg;
                        wr_en        = 1'b1;
                        next_id_next = next_id_reg + 1'b1;
                    end
                end
            end
            dtq_pkg::S_UNREG: begin
                step = !(at_end && !out_free);
                if (step) begin
                    if (at_end) begin
                        emit       = 1'b1;
                        e_status   = dtq_pkg::ST_UNREG;
                        e_id       = key_reg;
                        state_next = dtq_pkg::S_IDLE;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            dtq_pkg::S_TICK: begin
                // the held fire goes out once the next sweep shows whether it is the last
                step = !(at_end && (pend_reg || !tail_carry.bf) && !out_free);
                if (step) begin
                    if (at_end) begin
                        emit = pend_reg || !tail_carry.bf;
                        if (pend_reg) begin
                            e_status = dtq_pkg::ST_FIRED;
                            e_id     = pend_id_reg;
                            e_last   = !tail_carry.bf;
                        end
                        pos_next = '0;
                        if (tail_carry.bf) begin
                            pend_next    = 1'b1;
                            pend_id_next = tail_carry.bid;
                            tgt_v_next   = 1'b1;
                            tgt_next     = tail_bidx;
                        end else begin
                            pend_next  = 1'b0;
                            tgt_v_next = 1'b0;
                            state_next = dtq_pkg::S_IDLE;
                        end
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default: state_next = dtq_pkg::S_IDLE;
        endcase

        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_id_next     = m_id_reg;
        m_last_next   = m_last_reg;
        if (emit) begin
            m_valid_next  = 1'b1;
            m_status_next = e_status;
            m_id_next     = e_id;
            m_last_next   = e_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dtq_pkg::S_IDLE;
            pos_reg     <= '0;
            tgt_v_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            next_id_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            tgt_v_reg   <= tgt_v_next;
            pend_reg    <= pend_next;
            next_id_reg <= next_id_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tgt_reg      <= tgt_next;
        pend_id_reg  <= pend_id_next;
        dl_reg       <= dl_next;
        key_reg      <= key_next;
        now_reg      <= now_next;
        m_status_reg <= m_status_next;
        m_id_reg     <= m_id_next;
        m_last_reg   <= m_last_next;
    end

endmodule

`default_nettype wire

FILE: rtl/deadline_timer_queue.sv
// Earliest-deadline timer queue: a row of MAX_TASKS slot cells and a sequencer.
// Depends on dtq_pkg, dtq_cell and dtq_ctrl.
//
// Requests enter on the s_ channel (tuser = request kind, tdata = deadline,
// task id, now). Results leave on the m_ channel (tuser = status, tdata = id,
// tlast on the final result of a request). One request is worked at a time.
// Slots stay packed in registration order; a sweep wave walks the row one
// cell per cycle, removing an entry and looking for the earliest due
// deadline on the way.
//   register:   no sweep; the entry goes to the first free slot unless full.
//   unregister: a single sweep of the row.
//   tick:       sweeps until no entry is due; each sweep removes the
//               previous fire and finds the next one.
// A new request is accepted in the cycle after the previous one finishes,
// even while its last result still waits in the output register.
// Reset empties the table and restarts ids at zero at once; no sweep needed.
// While the receiver stalls, the sweep halts at the end of its pass and
// resumes when the output register is free.
`default_nettype none

module deadline_timer_queue #(
    parameter int MAX_TASKS = dtq_pkg::DEF_MAX_TASKS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [47:0] deadline, [63:48] task_id, [111:64] now
    input  wire logic [dtq_pkg::S_TDATA_W-1:0]       s_tdata,
    // [1:0] req_type
    input  wire logic [dtq_pkg::REQ_BITS-1:0]        s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [15:0] result_id
    output logic [dtq_pkg::M_TDATA_W-1:0]            m_tdata,
    output logic                                     m_tlast,
    // [2:0] status
    output logic [dtq_pkg::STATUS_BITS-1:0]          m_tuser
);

    localparam int IW = $clog2(MAX_TASKS);

    dtq_pkg::ctrl_t  cell_ctrl;
    logic [IW-1:0]   pos;
    logic [IW-1:0]   tgt;
    dtq_pkg::entry_t ent      [MAX_TASKS];
    dtq_pkg::carry_t cq       [MAX_TASKS];
    dtq_pkg::carry_t co       [MAX_TASKS];
    logic [IW-1:0]   bq       [MAX_TASKS];
    logic [IW-1:0]   bo       [MAX_TASKS];
    logic [MAX_TASKS-1:0] vvec;

    for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
        logic            prev_valid;
        dtq_pkg::carry_t carry_in;
        logic [IW-1:0]   bidx_in;
        dtq_pkg::entry_t next_entry;

        if (i == 0) begin : g_head
            assign prev_valid = 1'b1;
            assign carry_in   = '0;
            assign bidx_in    = '0;
        end else begin : g_body
            assign prev_valid = ent[i-1].valid;
            assign carry_in   = cq[i-1];
            assign bidx_in    = bq[i-1];
        end

        if (i == MAX_TASKS - 1) begin : g_tail
            assign next_entry = '0;
        end else begin : g_mid
            assign next_entry = ent[i+1];
        end

        assign vvec[i] = ent[i].valid;

        dtq_cell #(
            .MAX_TASKS (MAX_TASKS),
            .INDEX     (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .pos        (pos),
            .tgt        (tgt),
            .prev_valid (prev_valid),
            .carry_in   (carry_in),
            .bidx_in    (bidx_in),
            .next_entry (next_entry),
            .entry      (ent[i]),
            .carry_q    (cq[i]),
            .bidx_q     (bq[i]),
            .carry_out  (co[i]),
            .bidx_out   (bo[i])
        );
    end

    dtq_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cell_ctrl  (cell_ctrl),
        .pos        (pos),
        .tgt        (tgt),
        .tail_carry (co[MAX_TASKS-1]),
        .tail_bidx  (bo[MAX_TASKS-1]),
        .table_full (ent[MAX_TASKS-1].valid)
    );

    // slots are packed from the low end whenever the block is idle
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> ((vvec & (vvec + 1'b1)) == '0))
        else $error("timer slots not packed while idle");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != dtq_pkg::ST_FIRED)) |-> m_tlast)
        else $error("single-result status without tlast");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= dtq_pkg::ST_NONE))
        else $error("undefined result status");

endmodule

`default_nettype wire

FILE: test/tb_deadline_timer_queue.sv
// Testbench for deadline_timer_queue: drives register, unregister and tick requests and
// checks every result against a predictor of the slot table and id counter.
// Depends on dtq_pkg and the deadline_timer_queue RTL.

typedef struct packed {
    logic [dtq_pkg::STATUS_BITS-1:0] status;
    logic [dtq_pkg::ID_BITS-1:0]     id;
    logic                            last;
} timer_result_t;

class dtq_scoreboard;
    localparam int SLOTS = dtq_pkg::DEF_MAX_TASKS;

    logic [dtq_pkg::TIME_BITS-1:0] slot_deadline [SLOTS];
    logic [dtq_pkg::ID_BITS-1:0]   slot_id [SLOTS];
    int                            used;
    logic [dtq_pkg::ID_BITS-1:0]   next_id;
    timer_result_t                 expected_results [$];
    int                            errors;

    function new();
        used = 0;
        next_id = '0;
        errors = 0;
    endfunction

    // Slots stay packed in registration order; removal shifts later ones down.
    function void drop_slot(int idx);
        for (int i = idx; i < used - 1; i++) begin
            slot_deadline[i] = slot_deadline[i + 1];
            slot_id[i] = slot_id[i + 1];
        end
        used--;
    endfunction

    function void note_request(logic [dtq_pkg::REQ_BITS-1:0] req,
                               logic [dtq_pkg::TIME_BITS-1:0] deadline,
                               logic [dtq_pkg::ID_BITS-1:0] task_id,
                               logic [dtq_pkg::TIME_BITS-1:0] now);
        int best;
        int fired;
        case (req)
            dtq_pkg::REQ_REGISTER: begin
                if (used >= SLOTS) begin
                    expected_results.push_back('{dtq_pkg::ST_FULL, '0, 1'b1});
                end else begin
                    slot_deadline[used] = deadline;
                    slot_id[used] = next_id;
                    used++;
                    expected_results.push_back('{dtq_pkg::ST_REGISTERED, next_id, 1'b1});
                    next_id = next_id + 1'b1;
                end
            end
            dtq_pkg::REQ_UNREGISTER: begin
                for (int i = 0; i < used; i++) begin
                    if (slot_id[i] == task_id) begin
                        drop_slot(i);
                        break;
                    end
                end
                expected_results.push_back('{dtq_pkg::ST_UNREG, task_id, 1'b1});
            end
            dtq_pkg::REQ_TICK: begin
                fired = 0;
                forever begin
                    best = -1;
                    for (int i = 0; i < used; i++) begin
                        if (slot_deadline[i] <= now &&
                            (best < 0 || slot_deadline[i] < slot_deadline[best]))
                            best = i;
                    end
                    if (best < 0)
                        break;
                    expected_results.push_back('{dtq_pkg::ST_FIRED, slot_id[best], 1'b0});
                    drop_slot(best);
                    fired++;
                end
                if (fired == 0)
                    expected_results.push_back('{dtq_pkg::ST_NONE, '0, 1'b1});
                else
                    expected_results[expected_results.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    task report(string what);
        errors++;
        $display("ERROR: %s", what);
    endtask

    task check_result(logic [dtq_pkg::STATUS_BITS-1:0] status,
                      logic [dtq_pkg::ID_BITS-1:0] id, logic last);
        timer_result_t exp;
        if (expected_results.size() == 0) begin
            report($sformatf("unexpected result status %0d id %0d last %0b",
                             status, id, last));
        end else begin
            exp = expected_results.pop_front();
            if (status !== exp.status || id !== exp.id || last !== exp.last)
                report($sformatf({"got status %0d id %0d last %0b, ",
                                  "want status %0d id %0d last %0b"},
                                 status, id, last, exp.status, exp.id, exp.last));
        end
    endtask
endclass

module tb_deadline_timer_queue;

    localparam logic [dtq_pkg::REQ_BITS-1:0]  REQ_UNKNOWN = 2'd3;
    localparam logic [dtq_pkg::TIME_BITS-1:0] TIME_MAX    = {dtq_pkg::TIME_BITS{1'b1}};
    localparam int RANDOM_ITEMS = 275;
    localparam int HOLD_CYCLES  = 500;
    localparam int IDLE_LIMIT   = 3000;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [dtq_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [dtq_pkg::REQ_BITS-1:0]    s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [dtq_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tlast;
    logic [dtq_pkg::STATUS_BITS-1:0] m_tuser;

    dtq_scoreboard sb = new();

    bit use_gaps = 1'b0;
    bit rx_stalls = 1'b0;
    bit hold_req = 1'b0;
    int burst_left = 0;
    int idle_cycles = 0;

    deadline_timer_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [dtq_pkg::TIME_BITS-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[dtq_pkg::TIME_BITS-1:0];
    endfunction

    task automatic send_request(input logic [dtq_pkg::REQ_BITS-1:0] req,
                                input logic [dtq_pkg::TIME_BITS-1:0] deadline,
                                input logic [dtq_pkg::ID_BITS-1:0] task_id,
                                input logic [dtq_pkg::TIME_BITS-1:0] now);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (use_gaps) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tdata = {now, task_id, deadline};
        s_tuser = req;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req, deadline, task_id, now);
        burst_left--;
    endtask

    // Receiver: alternating ready and stall runs, a long hold-off on request.
    initial begin
        int run_left;
        bit stalling;
        run_left = 0;
        stalling = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                run_left = 0;
            end else if (!rx_stalls) begin
                m_tready = 1'b1;
            end else begin
                if (run_left == 0) begin
                    stalling = !stalling;
                    if (stalling)
                        run_left = $urandom_range(1, 6);
                    else if ($urandom_range(0, 7) == 0)
                        run_left = $urandom_range(40, 80);
                    else
                        run_left = $urandom_range(1, 12);
                end
                m_tready = !stalling;
                run_left--;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [dtq_pkg::TIME_BITS-1:0] directed_deadlines [16];
        logic [dtq_pkg::TIME_BITS-1:0] cur_time;
        logic [dtq_pkg::TIME_BITS-1:0] dl;
        logic [dtq_pkg::TIME_BITS-1:0] tnow;
        logic [dtq_pkg::ID_BITS-1:0]   tid;
        int                            pick;
        int                            n;
        bit                            held;

        directed_deadlines = '{48'd5, 48'd0, TIME_MAX, 48'd5, 48'd0, 48'hAAAA_AAAA_AAAA,
                               48'h5555_5555_5555, 48'd7, 48'h8000_0000_0000, 48'd1,
                               48'h7FFF_FFFF_FFFF, 48'd100, 48'd3, 48'hFFFF_FFFF_FFFE,
                               48'd2, 48'd100};

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty tick, absent id, ignored kind, full table, ties, flush.
        use_gaps = 1'b1;
        rx_stalls = 1'b1;
        send_request(dtq_pkg::REQ_TICK, '0, '0, '0);
        send_request(dtq_pkg::REQ_UNREGISTER, '0, 16'hFFFF, '0);
        send_request(REQ_UNKNOWN, TIME_MAX, 16'hFFFF, TIME_MAX);
        for (int i = 0; i < 16; i++)
            send_request(dtq_pkg::REQ_REGISTER, directed_deadlines[i], '0, '0);
        send_request(dtq_pkg::REQ_REGISTER, 48'd9, '0, '0);
        send_request(dtq_pkg::REQ_UNREGISTER, '0, 16'd3, '0);
        send_request(dtq_pkg::REQ_TICK, '0, '0, '0);
        send_request(dtq_pkg::REQ_TICK, '0, '0, TIME_MAX);
        send_request(dtq_pkg::REQ_TICK, '0, '0, TIME_MAX);

        // Random traffic around a slowly advancing time base.
        cur_time = 48'd1000;
        n = 0;
        held = 1'b0;
        while (n < RANDOM_ITEMS) begin
            use_gaps = ((n / 50) % 3) != 2;
            rx_stalls = ((n / 50) % 4) != 3;
            if (n == 120 && !held) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 43) begin
                dl = ($urandom_range(0, 9) == 0) ? rand_time()
                                                 : cur_time + $urandom_range(0, 300);
                send_request(dtq_pkg::REQ_REGISTER, dl, 16'($urandom), rand_time());
                n++;
            end else if (pick < 60) begin
                if (sb.used > 0 && $urandom_range(0, 4) != 0)
                    tid = sb.slot_id[$urandom_range(0, sb.used - 1)];
                else
                    tid = 16'($urandom);
                send_request(dtq_pkg::REQ_UNREGISTER, rand_time(), tid, rand_time());
                n++;
            end else if (pick < 96) begin
                cur_time = cur_time + $urandom_range(0, 80);
                case ($urandom_range(0, 39))
                    0:       tnow = TIME_MAX;
                    1, 2:    tnow = rand_time();
                    3, 4:    tnow = cur_time + 400;
                    default: tnow = cur_time;
                endcase
                send_request(dtq_pkg::REQ_TICK, rand_time(), 16'($urandom), tnow);
                n++;
            end else begin
                send_request(REQ_UNKNOWN, rand_time(), 16'($urandom), rand_time());
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        rx_stalls = 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.expected_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_results.size()));
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
